// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive while reset is high
`define TLL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, inactive while reset is high
`define TLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tll_pkg.sv
`default_nettype none

package tll_pkg;

   // node index and queue position widths, node table depth and leaf cap
   localparam int IDX_W       = 4;
   localparam int NODE_DEPTH  = 16;
   localparam int POS_W       = 5;
   localparam int LEAF_CAP    = 16;

   // stream word widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic root;
      logic step;
      logic flush;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/tll_ctrl.sv
`default_nettype none

module tll_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tlast,
   output logic                     req_tready,
   input  wire tll_pkg::status_type status,
   output tll_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROOT,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   assign req_tready = ready_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.out_free) begin
               if (status.walk_done) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_LOAD);
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tll_datapath.sv
`default_nettype none

module tll_datapath #(
   parameter int MAX_NODES = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tll_pkg::cmd_type         cmd,
   output tll_pkg::status_type           status,
   input  wire logic [tll_pkg::IDX_W-1:0] left_index,
   input  wire logic                     has_left,
   input  wire logic [tll_pkg::IDX_W-1:0] right_index,
   input  wire logic                     has_right,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output logic [tll_pkg::IDX_W-1:0]     leaf_index,
   output logic                          last_leaf
);

   localparam int IDX_W = tll_pkg::IDX_W;
   localparam int POS_W = tll_pkg::POS_W;
   localparam int DEPTH = tll_pkg::NODE_DEPTH;
   localparam int DEQ_W = $clog2(MAX_NODES + 1);

   // node tables, written once per record up to the sixteenth, and the walk queue
   logic [IDX_W-1:0] lchild_ff [DEPTH];
   logic [IDX_W-1:0] rchild_ff [DEPTH];
   logic [DEPTH-1:0] lvalid_ff;
   logic [DEPTH-1:0] rvalid_ff;
   logic [IDX_W-1:0] queue_ff  [DEPTH];

   logic [DEPTH-1:0] parent_ff,   parent_in;
   logic [POS_W-1:0] cnt_ff,      cnt_in;
   logic [POS_W-1:0] rd_ff,       rd_in;
   logic [POS_W-1:0] wr_ff,       wr_in;
   logic [DEQ_W-1:0] deq_ff,      deq_in;
   logic [POS_W-1:0] leaf_cnt_ff, leaf_cnt_in;
   logic             pend_v_ff,   pend_v_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             rsp_v_ff,    rsp_v_in;
   logic [IDX_W-1:0] rsp_idx_ff,  rsp_idx_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0] node;
   logic             lok, rok;
   logic [POS_W-1:0] rd_pop, wr_a, wr_b;
   logic             push_l, push_r;
   logic             emit_leaf;
   logic [IDX_W-1:0] root_idx;
   logic             load_ok;

   // head of queue and its children
   always_comb begin
      node   = queue_ff[rd_ff[IDX_W-1:0]];
      lok    = lvalid_ff[node] && ({1'b0, lchild_ff[node]} < cnt_ff);
      rok    = rvalid_ff[node] && ({1'b0, rchild_ff[node]} < cnt_ff);
      rd_pop = rd_ff + POS_W'(1);
      push_l = lok && ((wr_ff - rd_pop) < POS_W'(DEPTH));
      wr_a   = push_l ? wr_ff + POS_W'(1) : wr_ff;
      push_r = rok && ((wr_a - rd_pop) < POS_W'(DEPTH));
      wr_b   = push_r ? wr_a + POS_W'(1) : wr_a;
      emit_leaf = cmd.step && !lok && !rok && (leaf_cnt_ff < POS_W'(tll_pkg::LEAF_CAP));
      load_ok   = cnt_ff < POS_W'(DEPTH);
   end

   // lowest loaded node without a parent, node 0 if none
   always_comb begin
      root_idx = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (!parent_ff[k] && (POS_W'(k) < cnt_ff)) begin
            root_idx = IDX_W'(k);
         end
      end
   end

   assign status.walk_done = (deq_ff == DEQ_W'(MAX_NODES)) || (wr_ff == rd_ff);
   assign status.out_free  = !rsp_v_ff || rsp_tready;

   // next values of the control registers
   always_comb begin
      parent_in   = parent_ff;
      cnt_in      = cnt_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      deq_in      = deq_ff;
      leaf_cnt_in = leaf_cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_idx_in  = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.load && load_ok) begin
         cnt_in = cnt_ff + POS_W'(1);
         if (has_left) begin
            parent_in[left_index] = 1'b1;
         end
         if (has_right) begin
            parent_in[right_index] = 1'b1;
         end
      end
      if (cmd.root) begin
         rd_in       = '0;
         wr_in       = POS_W'(1);
         deq_in      = '0;
         leaf_cnt_in = '0;
         pend_v_in   = 1'b0;
      end
      if (cmd.step) begin
         rd_in  = rd_pop;
         wr_in  = wr_b;
         deq_in = deq_ff + DEQ_W'(1);
      end
      // a leaf is held back one step so the final one can be flagged
      if (emit_leaf) begin
         if (pend_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_idx_in  = pend_idx_ff;
            rsp_last_in = 1'b0;
         end
         pend_idx_in = node;
         pend_v_in   = 1'b1;
         leaf_cnt_in = leaf_cnt_ff + POS_W'(1);
      end
      if (cmd.flush) begin
         if (pend_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_idx_in  = pend_idx_ff;
            rsp_last_in = 1'b1;
         end
         pend_v_in = 1'b0;
         parent_in = '0;
         cnt_in    = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         parent_ff   <= '0;
         cnt_ff      <= '0;
         rd_ff       <= '0;
         wr_ff       <= '0;
         deq_ff      <= '0;
         leaf_cnt_ff <= '0;
         pend_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         parent_ff   <= parent_in;
         cnt_ff      <= cnt_in;
         rd_ff       <= rd_in;
         wr_ff       <= wr_in;
         deq_ff      <= deq_in;
         leaf_cnt_ff <= leaf_cnt_in;
         pend_v_ff   <= pend_v_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // node tables and walk queue
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         lchild_ff[cnt_ff[IDX_W-1:0]] <= left_index;
         lvalid_ff[cnt_ff[IDX_W-1:0]] <= has_left;
         rchild_ff[cnt_ff[IDX_W-1:0]] <= right_index;
         rvalid_ff[cnt_ff[IDX_W-1:0]] <= has_right;
      end
      if (cmd.root) begin
         queue_ff[0] <= root_idx;
      end
      if (cmd.step) begin
         if (push_l) begin
            queue_ff[wr_ff[IDX_W-1:0]] <= lchild_ff[node];
         end
         if (push_r) begin
            queue_ff[wr_a[IDX_W-1:0]] <= rchild_ff[node];
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign leaf_index = rsp_idx_ff;
   assign last_leaf  = rsp_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tree_leaves_level_order_top.sv
// Breadth-first leaf lister for a binary tree of up to 16 nodes. Node records stream in one
// word per cycle while req_tready is high, the k-th word describing node k; the word with
// tlast starts the walk. The root is the lowest loaded node that no record names as a child
// (node 0 if there is none); child indices at or beyond the number of loaded nodes count as
// absent, and records past the sixteenth are dropped apart from their tlast. The walk runs
// through a 16-entry queue at one dequeue per cycle while the output is not stalled: after
// the records, a tree takes a root pick, its dequeues (at most MAX_NODES) and a closing
// step. Leaf indices come out in level order, at most 16, with tlast on the final one; a
// walk that finds no leaf gives no word. No input is taken from the tlast word until the
// closing step, after which the node count and parent flags are clear again.

`default_nettype none

module tree_leaves_level_order_top #(
   parameter int MAX_NODES = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // left_index[3:0], has_left[4], right_index[8:5], has_right[9], zero[15:10]
   input  wire logic [tll_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // last_node
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // leaf_index[3:0], zero[7:4]
   output logic [tll_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // last_leaf
   output logic                                   rsp_tlast
);

   localparam int IDX_W = tll_pkg::IDX_W;

   tll_pkg::cmd_type    cmd;
   tll_pkg::status_type status;
   logic [IDX_W-1:0]    leaf_index;

   // sequencer
   tll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // tables, queue and result register
   tll_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .left_index  (req_tdata[IDX_W-1:0]),
      .has_left    (req_tdata[IDX_W]),
      .right_index (req_tdata[2*IDX_W:IDX_W+1]),
      .has_right   (req_tdata[2*IDX_W+1]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .leaf_index  (leaf_index),
      .last_leaf   (rsp_tlast)
   );

   // result word packing
   assign rsp_tdata = {(tll_pkg::RSP_TDATA_W - IDX_W)'(0), leaf_index};

endmodule

`default_nettype wire

// File: hw/rtl/tll_checker.sv
`default_nettype none

`include "assert_macros.svh"

module tll_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [tll_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic                            req_tlast,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [tll_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast
);

   // a stalled result word holds
   `TLL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result word changed while stalled")

   // the closing record starts a walk, so input stops
   `TLL_ASSERT_NEXT(a_walk_blocks_input, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input taken right after the closing record")

   // a leaf that is not the final one only shows during a walk
   `TLL_ASSERT_NOW(a_mid_leaf_in_walk, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready, "non-final leaf pending while loading")

   // padding of the result word
   `TLL_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:4] == 4'd0, "result word padding not zero")

endmodule

bind tree_leaves_level_order_top tll_checker u_tll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WALK_LIMIT  = 16;
   localparam int NODE_SLOTS  = tll_pkg::NODE_DEPTH;
   localparam int CYCLE_LIMIT = 100000;
   localparam int DRAIN_WAIT  = 40;

   // one node record as it travels in req_tdata
   typedef struct packed {
      logic                     has_right;
      logic [tll_pkg::IDX_W-1:0] right_index;
      logic                     has_left;
      logic [tll_pkg::IDX_W-1:0] left_index;
   } node_rec_t;

   // one leaf word as it should come out
   typedef struct packed {
      logic [tll_pkg::IDX_W-1:0] leaf_index;
      logic                     last_leaf;
   } leaf_word_t;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [tll_pkg::REQ_TDATA_W-1:0]  req_tdata;
   logic                             req_tlast;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [tll_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   logic                             rsp_tlast;

   // leaves still owed by the block, oldest first
   leaf_word_t leaves_due[$];

   // predictor copy of the tree store
   logic [tll_pkg::IDX_W-1:0] left_tbl [NODE_SLOTS];
   logic [tll_pkg::IDX_W-1:0] right_tbl [NODE_SLOTS];
   bit                        left_ok [NODE_SLOTS];
   bit                        right_ok [NODE_SLOTS];
   bit                        parent_seen [NODE_SLOTS];
   int unsigned               nodes_held;

   int  errors;
   int  cycles;
   int  words_sent;
   int  trees_walked;
   int  leaves_seen;
   int  idle_pct;

   tree_leaves_level_order_top #(
      .MAX_NODES(WALK_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // clock, 4 ns period
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: run timed out after %0d cycles", $time, cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // clear the predicted tree store
   function automatic void clear_tree();
      for (int k = 0; k < NODE_SLOTS; k++) begin
         left_tbl[k]    = '0;
         right_tbl[k]   = '0;
         left_ok[k]     = 1'b0;
         right_ok[k]    = 1'b0;
         parent_seen[k] = 1'b0;
      end
      nodes_held = 0;
   endfunction

   // take one accepted record; on the last one walk the tree and queue the leaves
   function automatic void predict_leaves(node_rec_t rec, bit last_node);
      logic [tll_pkg::IDX_W-1:0] root;
      logic [tll_pkg::IDX_W-1:0] node;
      logic [tll_pkg::IDX_W-1:0] walk_fifo[$];
      leaf_word_t                found[$];
      leaf_word_t                lw;
      bit                        root_found;
      bit                        lok;
      bit                        rok;
      int                        dequeues;
      if (nodes_held < NODE_SLOTS) begin
         left_tbl[nodes_held]  = rec.left_index;
         left_ok[nodes_held]   = rec.has_left;
         right_tbl[nodes_held] = rec.right_index;
         right_ok[nodes_held]  = rec.has_right;
         if (rec.has_left)
            parent_seen[rec.left_index] = 1'b1;
         if (rec.has_right)
            parent_seen[rec.right_index] = 1'b1;
         nodes_held++;
      end
      if (!last_node)
         return;

      // root is the lowest loaded node nobody points at, else node 0
      root = '0;
      root_found = 1'b0;
      for (int k = 0; k < nodes_held; k++) begin
         if (!root_found && !parent_seen[k]) begin
            root = k[tll_pkg::IDX_W-1:0];
            root_found = 1'b1;
         end
      end

      // breadth first walk through a 16-entry queue
      walk_fifo.push_back(root);
      dequeues = 0;
      while (dequeues < WALK_LIMIT && walk_fifo.size() != 0) begin
         node = walk_fifo.pop_front();
         lok = left_ok[node] && (left_tbl[node] < nodes_held);
         rok = right_ok[node] && (right_tbl[node] < nodes_held);
         dequeues++;
         if (lok && walk_fifo.size() < NODE_SLOTS)
            walk_fifo.push_back(left_tbl[node]);
         if (rok && walk_fifo.size() < NODE_SLOTS)
            walk_fifo.push_back(right_tbl[node]);
         if (!lok && !rok && found.size() < tll_pkg::LEAF_CAP) begin
            lw.leaf_index = node;
            lw.last_leaf  = 1'b0;
            found.push_back(lw);
         end
      end
      if (found.size() > 0)
         found[found.size()-1].last_leaf = 1'b1;
      foreach (found[i])
         leaves_due.push_back(found[i]);
      trees_walked++;
      clear_tree();
   endfunction

   // receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // compare every accepted leaf word with the oldest prediction
   always @(posedge clock) begin
      leaf_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         leaves_seen++;
         if (leaves_due.size() == 0) begin
            $display("%0t: unexpected leaf word: expected none, got leaf %0d last %0b",
                     $time, rsp_tdata[tll_pkg::IDX_W-1:0], rsp_tlast);
            errors++;
         end else begin
            want = leaves_due.pop_front();
            if (rsp_tdata[tll_pkg::IDX_W-1:0] !== want.leaf_index) begin
               $display("%0t: leaf_index mismatch: expected %0d, got %0d",
                        $time, want.leaf_index, rsp_tdata[tll_pkg::IDX_W-1:0]);
               errors++;
            end
            if (rsp_tlast !== want.last_leaf) begin
               $display("%0t: last_leaf mismatch: expected %0b, got %0b",
                        $time, want.last_leaf, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[tll_pkg::RSP_TDATA_W-1:tll_pkg::IDX_W] !== '0) begin
               $display("%0t: rsp_tdata padding mismatch: expected 0, got %h",
                        $time, rsp_tdata[tll_pkg::RSP_TDATA_W-1:tll_pkg::IDX_W]);
               errors++;
            end
         end
      end
   end

   // send one node record; called and returning at a falling edge
   task automatic send_node(input logic [3:0] li, input bit hl, input logic [3:0] ri,
                            input bit hr, input bit last_node);
      node_rec_t rec;
      rec.left_index  = li;
      rec.has_left    = hl;
      rec.right_index = ri;
      rec.has_right   = hr;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(tll_pkg::REQ_TDATA_W - $bits(node_rec_t)){1'b0}}, rec};
      req_tlast  = last_node;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_leaves(rec, last_node);
      words_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every predicted leaf has come out
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (leaves_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // a random well-formed tree of n nodes, node numbering shuffled
   task automatic send_random_tree(input int n);
      int        order [NODE_SLOTS];
      logic [3:0] lc [NODE_SLOTS];
      logic [3:0] rc [NODE_SLOTS];
      bit        hl [NODE_SLOTS];
      bit        hr [NODE_SLOTS];
      int        j;
      int        tmp;
      int        par;
      bit        placed;
      for (int k = 0; k < NODE_SLOTS; k++) begin
         order[k] = k;
         lc[k] = 4'($urandom_range(15));
         rc[k] = 4'($urandom_range(15));
         hl[k] = 1'b0;
         hr[k] = 1'b0;
      end
      for (int k = n - 1; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      // hang each node under an earlier one with a free slot
      for (int i = 1; i < n; i++) begin
         placed = 1'b0;
         while (!placed) begin
            par = order[$urandom_range(i - 1)];
            if ($urandom_range(1) == 0 && !hl[par]) begin
               hl[par] = 1'b1;
               lc[par] = 4'(order[i]);
               placed = 1'b1;
            end else if (!hr[par]) begin
               hr[par] = 1'b1;
               rc[par] = 4'(order[i]);
               placed = 1'b1;
            end
         end
      end
      for (int k = 0; k < n; k++)
         send_node(lc[k], hl[k], rc[k], hr[k], k == n - 1);
   endtask

   // random records: loops, shared children, out of range children, overlong trees
   task automatic send_noise_tree(input int n);
      for (int k = 0; k < n; k++)
         send_node(4'($urandom_range(15)), 1'($urandom_range(1)), 4'($urandom_range(15)),
                   1'($urandom_range(1)), k == n - 1);
   endtask

   // a lone node is its own leaf
   task automatic test_single_node();
      send_node(4'd0, 1'b0, 4'd15, 1'b0, 1'b1);
   endtask

   // left child 15 lies beyond a two-node tree and counts as absent
   task automatic test_child_out_of_range();
      send_node(4'd15, 1'b1, 4'd1, 1'b1, 1'b0);
      send_node(4'd0, 1'b0, 4'd0, 1'b0, 1'b1);
   endtask

   // every node has a parent: root falls back to node 0, walk finds no leaf
   task automatic test_no_parentless_node();
      send_node(4'd1, 1'b1, 4'd0, 1'b0, 1'b0);
      send_node(4'd0, 1'b1, 4'd0, 1'b0, 1'b1);
   endtask

   // self loop on both sides fills the queue and runs to the walk limit
   task automatic test_queue_overflow();
      send_node(4'd0, 1'b1, 4'd0, 1'b1, 1'b1);
   endtask

   // sixteen records of a full tree, then a seventeenth that only ends the tree
   task automatic test_record_overflow();
      for (int k = 0; k < NODE_SLOTS; k++)
         send_node(4'((2 * k + 1) % 16), (2 * k + 1) < 16, 4'((2 * k + 2) % 16),
                   (2 * k + 2) < 16, 1'b0);
      send_node(4'd15, 1'b1, 4'd0, 1'b1, 1'b1);
   endtask

   // mostly well-formed trees with random shape, some noise
   task automatic test_random_trees(input int word_goal);
      while (words_sent < word_goal) begin
         if ($urandom_range(99) < 78) begin
            if ($urandom_range(9) == 0)
               send_random_tree(NODE_SLOTS);
            else
               send_random_tree($urandom_range(1, 10));
         end else begin
            send_noise_tree($urandom_range(1, 19));
         end
      end
   endtask

   // a stretch with no idling on either side
   task automatic test_back_to_back(input int word_goal);
      idle_pct = 0;
      while (words_sent < word_goal)
         send_random_tree($urandom_range(1, 16));
      wait_drained();
      idle_pct = 13;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      errors       = 0;
      cycles       = 0;
      words_sent   = 0;
      trees_walked = 0;
      leaves_seen  = 0;
      idle_pct     = 13;
      clear_tree();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_node();
      test_child_out_of_range();
      test_no_parentless_node();
      test_queue_overflow();
      wait_drained();
      test_record_overflow();
      wait_drained();
      test_random_trees(180);
      test_back_to_back(220);
      test_random_trees(250);
      wait_drained();

      $display("covered %0d node words over %0d trees, %0d leaf words checked",
               words_sent, trees_walked, leaves_seen);
      $display("shapes: lone node, out of range child, loops, full queue, overlong tree");
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
